>>> rtl/core/red_pkg.sv
package red_pkg;

  localparam int unsigned CountW = 4;
  localparam logic [CountW-1:0] SettleReset = 4'd5;

  // pin level pair, bit 0 is channel a, bit 1 is channel b
  typedef logic [1:0] level_t;
  localparam level_t LvlNone = 2'b00;
  localparam level_t LvlA    = 2'b01;
  localparam level_t LvlB    = 2'b10;
  localparam level_t LvlAB   = 2'b11;

  typedef enum logic [1:0] {
    EvNone  = 2'd0,
    EvLeft  = 2'd1,
    EvRight = 2'd2
  } turn_event_e;

  typedef enum logic [6:0] {
    PhIdle = 7'b0000001,
    PhL1   = 7'b0000010,
    PhL2   = 7'b0000100,
    PhL3   = 7'b0001000,
    PhR1   = 7'b0010000,
    PhR2   = 7'b0100000,
    PhR3   = 7'b1000000
  } phase_e;

  // settled level change handed to the detent sequencer
  typedef struct packed {
    logic   valid;
    level_t level;
  } adv_t;

endpackage

>>> rtl/core/red_seq.sv
module red_seq
  import red_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  adv_t        adv_i,
  output turn_event_e event_o
);

  phase_e phase_q, phase_d;
  phase_e nx;
  turn_event_e ev;

  always_comb begin
    nx = PhIdle;
    ev = EvNone;
    if (adv_i.level == LvlB && phase_q != PhR2) begin
      nx = PhL1;
    end else if (adv_i.level == LvlA && phase_q != PhL2) begin
      nx = PhR1;
    end else if (phase_q == PhL2 && adv_i.level == LvlA) begin
      nx = PhL3;
    end else if (phase_q == PhR1 && adv_i.level == LvlNone) begin
      nx = PhR2;
    end else if (phase_q == PhR3 && adv_i.level == LvlAB) begin
      ev = EvRight;
    end else if (phase_q == PhL1 && adv_i.level == LvlNone) begin
      nx = PhL2;
    end else if (phase_q == PhL3 && adv_i.level == LvlAB) begin
      ev = EvLeft;
    end else if (phase_q == PhR2 && adv_i.level == LvlB) begin
      nx = PhR3;
    end
  end

  assign phase_d = adv_i.valid ? nx : phase_q;
  assign event_o = adv_i.valid ? ev : EvNone;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PhIdle;
    end else begin
      phase_q <= phase_d;
    end
  end

  a_phase_onehot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot(phase_q))
    else $error("detent phase not one-hot");

  // a completed path clears the sequencer in the same step
  a_event_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    event_o != EvNone |=> phase_q == PhIdle)
    else $error("phase not idle after event");

  a_event_on_both: assert property (@(posedge clk_i) disable iff (!rst_ni)
    event_o != EvNone |-> adv_i.level == LvlAB)
    else $error("event without both channels high");

endmodule

>>> rtl/core/rotary_encoder_detent_decoder.sv
// channel    dir  fields (lsb first)                         handshake
// s_axis     in   pin_a, pin_b                               tvalid / tready
// m_axis     out  turn_event[1:0], settled_a, settled_b      tvalid / tready
// cfg        in   settle_samples[3:0]                        cfg_we_i only
//
// one sample a cycle while s_axis_tready is high; its result is in the output register the next cycle
// debounce counter and detent sequencer update in the same cycle as the accept
// reset clears levels, count and phase; settle_samples returns to 5
// s_axis_tready drops only while a result waits and m_axis_tready is low
module rotary_encoder_detent_decoder
  import red_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       cfg_we_i,
  input  logic [3:0] cfg_wdata_i,    // settle_samples
  input  logic       s_axis_tvalid,
  output logic       s_axis_tready,
  input  logic [7:0] s_axis_tdata,   // [0] pin_a, [1] pin_b, rest zero
  output logic       m_axis_tvalid,
  input  logic       m_axis_tready,
  output logic [7:0] m_axis_tdata    // [1:0] turn_event, [2] settled_a, [3] settled_b
);

  logic [CountW-1:0] settle_q;
  level_t            settled_q, settled_d;
  level_t            cand_q, cand_d;
  logic [CountW-1:0] count_q, count_d;
  logic              out_valid_q;
  logic [3:0]        out_data_q;
  logic              accept;
  level_t            lvl;
  adv_t              adv;
  turn_event_e       ev;

  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready;
  assign lvl           = s_axis_tdata[1:0];

  always_comb begin
    settled_d = settled_q;
    cand_d    = cand_q;
    count_d   = count_q;
    adv.valid = 1'b0;
    adv.level = cand_q;
    if (lvl != settled_q) begin
      if (lvl == cand_q) begin
        count_d = count_q + 1'b1;
      end else begin
        count_d = '0;
        cand_d  = lvl;
      end
      if (count_d == settle_q) begin
        settled_d = cand_d;
        adv.valid = accept;
      end
      adv.level = cand_d;
    end
  end

  red_seq u_seq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .event_o (ev)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      settle_q    <= SettleReset;
      settled_q   <= LvlNone;
      cand_q      <= LvlNone;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        settle_q <= cfg_wdata_i;
      end
      if (accept) begin
        settled_q   <= settled_d;
        cand_q      <= cand_d;
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      out_data_q <= {settled_d, ev};
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'b0000, out_data_q};

  a_settled_on_accept: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !accept |=> $stable(settled_q))
    else $error("settled level moved without an item");

  // a level is only taken over once the count reaches the setting
  a_settle_count: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && settled_d != settled_q |-> count_d == settle_q)
    else $error("level settled before count matched");

  a_out_event_level: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_data_q[1:0] != EvNone |-> out_data_q[3:2] == LvlAB)
    else $error("event reported on wrong settled level");

endmodule

>>> sim/tb.sv
`timescale 1ns / 1ps

module tb;
  import red_pkg::*;

  logic       clk_i;
  logic       rst_ni;
  logic       cfg_we_i;
  logic [3:0] cfg_wdata_i;
  logic       s_axis_tvalid;
  logic       s_axis_tready;
  logic [7:0] s_axis_tdata;   // [0] pin_a, [1] pin_b, rest zero
  logic       m_axis_tvalid;
  logic       m_axis_tready;
  logic [7:0] m_axis_tdata;   // [1:0] turn_event, [2] settled_a, [3] settled_b

  rotary_encoder_detent_decoder dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  typedef struct {
    turn_event_e turn;
    logic        settled_a;
    logic        settled_b;
  } decoded_sample_t;

  // model of the debouncer and detent sequencer
  logic [3:0]  settle_cfg;
  level_t      settled_lvl;
  level_t      cand_lvl;
  logic [3:0]  agree_cnt;
  phase_e      detent_ph;

  decoded_sample_t decoded_q[$];
  int              err_count;
  int              items_sent;
  int              burst_left;
  bit              tx_gaps;
  bit              rx_stalls;
  int              stall_left;

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #10_000_000;
    $display("tb: FAIL");
    $finish;
  end

  function automatic turn_event_e step_detent(level_t lvl);
    phase_e      nx;
    turn_event_e ev;
    nx = PhIdle;
    ev = EvNone;
    if (lvl == LvlB && detent_ph != PhR2) begin
      nx = PhL1;
    end else if (lvl == LvlA && detent_ph != PhL2) begin
      nx = PhR1;
    end else if (detent_ph == PhL2 && lvl == LvlA) begin
      nx = PhL3;
    end else if (detent_ph == PhR1 && lvl == LvlNone) begin
      nx = PhR2;
    end else if (detent_ph == PhR3 && lvl == LvlAB) begin
      ev = EvRight;
    end else if (detent_ph == PhL1 && lvl == LvlNone) begin
      nx = PhL2;
    end else if (detent_ph == PhL3 && lvl == LvlAB) begin
      ev = EvLeft;
    end else if (detent_ph == PhR2 && lvl == LvlB) begin
      nx = PhR3;
    end
    detent_ph = nx;
    return ev;
  endfunction

  function automatic decoded_sample_t decode_sample(level_t lvl);
    decoded_sample_t res;
    res.turn = EvNone;
    if (lvl != settled_lvl) begin
      // bounces back to the settled level leave the count alone
      if (lvl == cand_lvl) begin
        agree_cnt = agree_cnt + 4'd1;
      end else begin
        agree_cnt = '0;
        cand_lvl  = lvl;
      end
      if (agree_cnt == settle_cfg) begin
        settled_lvl = cand_lvl;
        res.turn    = step_detent(settled_lvl);
      end
    end
    res.settled_a = settled_lvl[0];
    res.settled_b = settled_lvl[1];
    return res;
  endfunction

  task automatic report_mismatch(string what, int unsigned exp_val, int unsigned got_val);
    err_count++;
    if (err_count <= 50) begin
      $display("tb: mismatch on %s at %0t: expected %0d, got %0d",
               what, $realtime, exp_val, got_val);
    end
  endtask

  task automatic send_sample(level_t lvl);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {6'b0, lvl};
    do @(posedge clk_i); while (!s_axis_tready);
    decoded_q.push_back(decode_sample(lvl));
    items_sent++;
    if (tx_gaps) begin
      if (burst_left == 0) begin
        s_axis_tvalid <= 1'b0;
        repeat ($urandom_range(1, 8)) @(posedge clk_i);
        burst_left = $urandom_range(0, 12);
      end else begin
        burst_left--;
      end
    end
  endtask

  // hold the sender until every decoded sample is back, then let the pipe settle
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (decoded_q.size() != 0) @(posedge clk_i);
    repeat (3) @(posedge clk_i);
  endtask

  task automatic write_settle(logic [3:0] val);
    drain();
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    settle_cfg = val;
    cfg_we_i   <= 1'b0;
  endtask

  task automatic repeat_sample(level_t lvl, int n);
    for (int k = 0; k < n; k++) send_sample(lvl);
  endtask

  // reset threshold of 5: the sixth matching sample settles the level
  task automatic test_reset_threshold();
    repeat_sample(LvlA, 6);
    drain();
  endtask

  task automatic test_directed_paths();
    write_settle(4'd0);
    // left path, then right path, then a broken path
    send_sample(LvlB);
    send_sample(LvlNone);
    send_sample(LvlA);
    send_sample(LvlAB);
    send_sample(LvlA);
    send_sample(LvlNone);
    send_sample(LvlB);
    send_sample(LvlAB);
    send_sample(LvlA);
    send_sample(LvlAB);
    // bounce to the settled level keeps the count, a third level restarts it
    write_settle(4'd2);
    send_sample(LvlB);
    send_sample(LvlAB);
    send_sample(LvlB);
    send_sample(LvlA);
    send_sample(LvlA);
    send_sample(LvlA);
  endtask

  // threshold lowered below the running count: count wraps through 16
  task automatic test_lowered_threshold();
    write_settle(4'd15);
    repeat_sample(LvlNone, 10);
    write_settle(4'd3);
    repeat_sample(LvlNone, 12);
    write_settle(4'd15);
    repeat_sample(LvlB, 16);
  endtask

  task automatic run_detent(bit go_right);
    level_t path[4];
    int     hold;
    if (go_right) begin
      path = '{LvlA, LvlNone, LvlB, LvlAB};
    end else begin
      path = '{LvlB, LvlNone, LvlA, LvlAB};
    end
    foreach (path[i]) begin
      hold = int'(settle_cfg) + 1 + $urandom_range(0, 2);
      if ($urandom_range(0, 7) == 0) hold = $urandom_range(1, int'(settle_cfg) + 1);
      for (int k = 0; k < hold; k++) begin
        if ($urandom_range(0, 11) == 0) begin
          send_sample(level_t'($urandom_range(0, 3)));
        end else begin
          send_sample(path[i]);
        end
      end
    end
  endtask

  task automatic run_noise();
    int len;
    len = $urandom_range(1, 20);
    for (int k = 0; k < len; k++) begin
      repeat_sample(level_t'($urandom_range(0, 3)), $urandom_range(1, 4));
    end
  endtask

  task automatic test_random_traffic(int target);
    int         seqs;
    int         pick;
    logic [3:0] val;
    seqs = 0;
    while (items_sent < target) begin
      if (seqs % 8 == 0) begin
        pick = $urandom_range(0, 9);
        case (pick)
          0: val = 4'd0;
          1: val = 4'd15;
          2: val = 4'd1;
          default: val = 4'($urandom_range(1, 6));
        endcase
        write_settle(val);
        tx_gaps   = $urandom_range(0, 3) != 0;
        rx_stalls = $urandom_range(0, 3) != 0;
      end
      if ($urandom_range(0, 9) < 2) begin
        run_noise();
      end else begin
        run_detent($urandom_range(0, 1));
      end
      seqs++;
    end
  endtask

  // receiver stalls in runs of its own
  always @(posedge clk_i) begin
    if (!rx_stalls) begin
      m_axis_tready <= 1'b1;
    end else if (stall_left > 0) begin
      m_axis_tready <= 1'b0;
      stall_left--;
    end else begin
      m_axis_tready <= 1'b1;
      if ($urandom_range(0, 3) == 0) stall_left = $urandom_range(1, 6);
    end
  end

  always @(posedge clk_i) begin
    decoded_sample_t exp_res;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (decoded_q.size() == 0) begin
        report_mismatch("unexpected item", 0, m_axis_tdata);
      end else begin
        exp_res = decoded_q.pop_front();
        if (m_axis_tdata[1:0] != exp_res.turn) begin
          report_mismatch("turn_event", exp_res.turn, m_axis_tdata[1:0]);
        end
        if (m_axis_tdata[2] != exp_res.settled_a) begin
          report_mismatch("settled_a", exp_res.settled_a, m_axis_tdata[2]);
        end
        if (m_axis_tdata[3] != exp_res.settled_b) begin
          report_mismatch("settled_b", exp_res.settled_b, m_axis_tdata[3]);
        end
      end
    end
  end

  initial begin
    rst_ni        <= 1'b0;
    cfg_we_i      <= 1'b0;
    cfg_wdata_i   <= 4'd0;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= 8'd0;
    m_axis_tready <= 1'b0;
    settle_cfg  = SettleReset;
    settled_lvl = LvlNone;
    cand_lvl    = LvlNone;
    agree_cnt   = '0;
    detent_ph   = PhIdle;
    err_count   = 0;
    items_sent  = 0;
    burst_left  = 0;
    tx_gaps     = 1'b0;
    rx_stalls   = 1'b0;
    stall_left  = 0;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_reset_threshold();
    test_directed_paths();
    tx_gaps   = 1'b1;
    rx_stalls = 1'b1;
    test_lowered_threshold();
    test_random_traffic(1950);
    drain();

    if (err_count == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end

endmodule
